[src/rc_pwm_channel_normalizer_assert.svh]
// Assertion macros for the RC PWM channel normalizer.
`ifndef RC_PWM_CHANNEL_NORMALIZER_ASSERT_SVH
`define RC_PWM_CHANNEL_NORMALIZER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RCPN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcpn assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RCPN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcpn assertion failed");

`endif

[src/rcpn_pkg.sv]
// Shared constants for the RC PWM channel normalizer.
`timescale 1ns / 1ps

package rcpn_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int NUM_CH             = 5;
  localparam int ADDR_BITS          = 5;

  // input opcodes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // channel codes
  localparam logic [2:0] CH_ROLL     = 3'd0;
  localparam logic [2:0] CH_PITCH    = 3'd1;
  localparam logic [2:0] CH_THROTTLE = 3'd2;
  localparam logic [2:0] CH_YAW      = 3'd3;
  localparam logic [2:0] CH_SWITCH   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_TIMER_PERIOD   = 3'd0;
  localparam logic [2:0] REG_CALIBRATE_MODE = 3'd1;
  localparam logic [2:0] REG_THROTTLE_MIN   = 3'd2;
  localparam logic [2:0] REG_THROTTLE_MAX   = 3'd3;
  localparam logic [2:0] REG_ANGLE_MIN      = 3'd4;
  localparam logic [2:0] REG_ANGLE_MAX      = 3'd5;

  // register reset values
  localparam logic [15:0]        TIMER_PERIOD_RST = 16'd65535;
  localparam logic [14:0]        THROTTLE_MIN_RST = 15'd0;
  localparam logic [14:0]        THROTTLE_MAX_RST = 15'd1000;
  localparam logic signed [15:0] ANGLE_MIN_RST    = -16'sd90;
  localparam logic [14:0]        ANGLE_MAX_RST    = 15'd90;

  // default calibration table
  localparam logic [15:0] DEF_LOW [NUM_CH] = '{16'd16754, 16'd16832, 16'd16832,
                                               16'd16752, 16'd16736};
  localparam logic [15:0] DEF_HIGH [NUM_CH] = '{16'd29989, 16'd30036, 16'd30068,
                                                16'd29991, 16'd30020};
  localparam logic [15:0] DEF_CENTER [NUM_CH] = '{16'd23371, 16'd23434, 16'd23450,
                                                  16'd23371, 16'd23786};

  // shared divider: 32-bit dividend, 16-bit divisor, two quotient bits per cycle
  localparam int DIV_WIDTH     = 32;
  localparam int DIV_RADIX     = 2;
  localparam int DIV_STEPS     = DIV_WIDTH / DIV_RADIX;
  localparam int DIV_STEP_BITS = $clog2(DIV_STEPS);

endpackage

[src/rc_pwm_channel_normalizer.sv]
// Top level of the RC PWM channel normalizer: capture update and shared divider.
//
//   port group   direction  handshake         fields
//   config       in/out     APB write/read    paddr, pwdata, prdata
//   in           in         in_valid/in_stall opcode, channel, rise_time, fall_time
//   out          out        out_valid/out_stall throttle, rudder, roll, pitch,
//                                             switch_on, link_online
//
// Each accepted word goes through an update step, then four divisions
// (throttle, yaw, roll, pitch) on the single shared divider (multiply,
// 16 radix-4 steps, sign and clamp), then one load into the output register.
// The block takes no new word until the result is in the output register.
// A stalled output holds its result; the next result waits in the load step.
// Reset is synchronous and restores the configuration registers, the sequencer and the default calibration table.
`timescale 1ns / 1ps
`include "rc_pwm_channel_normalizer_assert.svh"

module rc_pwm_channel_normalizer #(
  parameter int TIMER_BITS = rcpn_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcpn_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [2:0]                     channel,
  input  logic [15:0]                    rise_time,
  input  logic [15:0]                    fall_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [14:0]                    throttle,
  output logic signed [15:0]             rudder,
  output logic signed [15:0]             roll,
  output logic signed [15:0]             pitch,
  output logic                           switch_on,
  output logic                           link_online
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UPDATE = 6'b000010,
    S_MUL    = 6'b000100,
    S_DIV    = 6'b001000,
    S_FIN    = 6'b010000,
    S_PUSH   = 6'b100000
  } state_t;

  localparam int DW = rcpn_pkg::DIV_WIDTH;

  // configuration registers
  logic [15:0]        timer_period;
  logic               calibrate_mode;
  logic [14:0]        thr_floor;
  logic [14:0]        thr_ceil;
  logic signed [15:0] angle_min;
  logic [14:0]        angle_max;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cal_clear;

  // channel state
  logic [15:0] pulse_width [rcpn_pkg::NUM_CH];
  logic [15:0] cal_low     [rcpn_pkg::NUM_CH];
  logic [15:0] cal_high    [rcpn_pkg::NUM_CH];
  logic [15:0] cal_center  [rcpn_pkg::NUM_CH];
  logic        online_flag;

  // sequencer
  state_t                           state;
  logic [2:0]                       ch_idx;
  logic [rcpn_pkg::DIV_STEP_BITS-1:0] step_cnt;
  logic                             op_r;
  logic [15:0]                      rise_r;
  logic [15:0]                      fall_r;

  // divider
  logic [DW-1:0] dvd;
  logic [DW-1:0] dvd_next;
  logic [15:0]   rem;
  logic [15:0]   rem_next;
  logic [15:0]   dsr;
  logic          q_neg;
  logic          den_zero;
  logic          num_zero;

  // per-division results
  logic [14:0] thr_res;
  logic [15:0] yaw_res;
  logic [15:0] roll_res;
  logic [15:0] pitch_res;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign cfg_idx   = paddr[rcpn_pkg::ADDR_BITS-1:2];
  assign cal_clear = cfg_wr && (cfg_idx == rcpn_pkg::REG_CALIBRATE_MODE) && pwdata[0];
  assign in_stall  = rst || (state != S_IDLE);

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period   <= rcpn_pkg::TIMER_PERIOD_RST;
      calibrate_mode <= 1'b0;
      thr_floor      <= rcpn_pkg::THROTTLE_MIN_RST;
      thr_ceil       <= rcpn_pkg::THROTTLE_MAX_RST;
      angle_min      <= rcpn_pkg::ANGLE_MIN_RST;
      angle_max      <= rcpn_pkg::ANGLE_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rcpn_pkg::REG_TIMER_PERIOD:   timer_period   <= pwdata[15:0];
        rcpn_pkg::REG_CALIBRATE_MODE: calibrate_mode <= pwdata[0];
        rcpn_pkg::REG_THROTTLE_MIN:   thr_floor      <= pwdata[14:0];
        rcpn_pkg::REG_THROTTLE_MAX:   thr_ceil       <= pwdata[14:0];
        rcpn_pkg::REG_ANGLE_MIN:      angle_min      <= $signed(pwdata[15:0]);
        rcpn_pkg::REG_ANGLE_MAX:      angle_max      <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rcpn_pkg::REG_TIMER_PERIOD:   prdata = {16'd0, timer_period};
      rcpn_pkg::REG_CALIBRATE_MODE: prdata = {31'd0, calibrate_mode};
      rcpn_pkg::REG_THROTTLE_MIN:   prdata = {17'd0, thr_floor};
      rcpn_pkg::REG_THROTTLE_MAX:   prdata = {17'd0, thr_ceil};
      rcpn_pkg::REG_ANGLE_MIN:      prdata = {{16{angle_min[15]}}, angle_min};
      rcpn_pkg::REG_ANGLE_MAX:      prdata = {17'd0, angle_max};
      default:                      prdata = 32'd0;
    endcase
  end

  // ---------------- capture update ----------------
  logic [TIMER_BITS-1:0] t_rise;
  logic [TIMER_BITS-1:0] t_fall;
  logic [TIMER_BITS-1:0] t_per;
  logic [TIMER_BITS-1:0] t_width;
  logic [15:0]           width16;
  logic                  cap_ok;
  logic [15:0]           upd_high;
  logic [15:0]           upd_low;
  logic [15:0]           upd_center;
  logic [16:0]           upd_sum;

  assign t_rise  = TIMER_BITS'(rise_r);
  assign t_fall  = TIMER_BITS'(fall_r);
  assign t_per   = TIMER_BITS'(timer_period);
  // wrap through the timer period when the fall stamp is not past the rise stamp
  assign t_width = (t_fall > t_rise) ? (t_fall - t_rise) : (t_fall + t_per - t_rise);
  assign width16 = (t_width > TIMER_BITS'(17'h0FFFF)) ? 16'hFFFF : 16'(t_width);

  assign cap_ok     = (op_r == rcpn_pkg::OP_CAPTURE) && (ch_idx < 3'(rcpn_pkg::NUM_CH));
  assign upd_high   = (width16 > cal_high[ch_idx]) ? width16 : cal_high[ch_idx];
  assign upd_low    = (width16 < cal_low[ch_idx]) ? width16 : cal_low[ch_idx];
  assign upd_sum    = {1'b0, upd_high} + {1'b0, upd_low};
  assign upd_center = upd_sum[16:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rcpn_pkg::NUM_CH; i++) begin
        pulse_width[i] <= 16'd0;
        cal_low[i]     <= rcpn_pkg::DEF_LOW[i];
        cal_high[i]    <= rcpn_pkg::DEF_HIGH[i];
        cal_center[i]  <= rcpn_pkg::DEF_CENTER[i];
      end
    end else if (cal_clear) begin
      for (int i = 0; i < rcpn_pkg::NUM_CH; i++) begin
        cal_low[i]    <= 16'hFFFF;
        cal_high[i]   <= 16'd0;
        cal_center[i] <= 16'd0;
      end
    end else if ((state == S_UPDATE) && cap_ok) begin
      pulse_width[ch_idx] <= width16;
      if (calibrate_mode) begin
        cal_high[ch_idx]   <= upd_high;
        cal_low[ch_idx]    <= upd_low;
        cal_center[ch_idx] <= upd_center;
      end
    end
  end

  // ---------------- numerator and divisor setup ----------------
  logic               is_thr;
  logic [15:0]        sel_low;
  logic [15:0]        sel_high;
  logic [15:0]        sel_center;
  logic [15:0]        v_sel;
  logic [15:0]        base;
  logic signed [16:0] diff;
  logic signed [16:0] den;
  logic [16:0]        diff_neg_val;
  logic [16:0]        den_neg_val;
  logic [15:0]        diff_mag;
  logic               diff_neg;
  logic [15:0]        den_mag;
  logic [14:0]        scale;
  logic [DW-1:0]      product;

  assign is_thr     = (ch_idx == rcpn_pkg::CH_THROTTLE);
  assign sel_low    = cal_low[ch_idx];
  assign sel_high   = cal_high[ch_idx];
  assign sel_center = cal_center[ch_idx];
  assign base       = is_thr ? sel_low : sel_center;
  // offline: failsafe to min for throttle, mid for the angles
  assign v_sel      = online_flag ? pulse_width[ch_idx] : base;
  assign diff       = $signed({1'b0, v_sel}) - $signed({1'b0, base});
  assign den        = is_thr ? ($signed({1'b0, sel_high}) - $signed({1'b0, sel_low}))
                             : ($signed({1'b0, sel_center}) - $signed({1'b0, sel_low}));
  assign diff_neg_val = 17'(-diff);
  assign den_neg_val  = 17'(-den);
  assign scale        = is_thr ? thr_ceil : angle_max;

  always_comb begin
    if (is_thr && (diff[16] || (diff == 17'sd0))) begin
      diff_mag = 16'd1;
      diff_neg = 1'b0;
    end else if (diff[16]) begin
      diff_mag = diff_neg_val[15:0];
      diff_neg = 1'b1;
    end else begin
      diff_mag = diff[15:0];
      diff_neg = 1'b0;
    end
    den_mag = den[16] ? den_neg_val[15:0] : den[15:0];
  end

  assign product = {16'd0, diff_mag} * {17'd0, scale};

  // ---------------- shared divider step ----------------
  logic [16:0] trial;

  always_comb begin
    rem_next = rem;
    dvd_next = dvd;
    trial    = 17'd0;
    for (int k = 0; k < rcpn_pkg::DIV_RADIX; k++) begin
      trial    = {rem_next, dvd_next[DW-1]};
      dvd_next = {dvd_next[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial       = trial - {1'b0, dsr};
        dvd_next[0] = 1'b1;
      end
      rem_next = trial[15:0];
    end
  end

  // ---------------- sign, saturation and clamp ----------------
  logic [DW-1:0]      q_mag;
  logic signed [33:0] q_val;
  logic signed [33:0] lo_bound;
  logic signed [33:0] hi_bound;
  logic signed [33:0] clamped;

  always_comb begin
    if (den_zero) begin
      q_mag = num_zero ? '0 : '1;
    end else begin
      q_mag = dvd;
    end
    q_val = q_neg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    if (is_thr) begin
      lo_bound = $signed({19'd0, thr_floor});
      hi_bound = $signed({19'd0, thr_ceil});
    end else begin
      lo_bound = {{18{angle_min[15]}}, angle_min};
      hi_bound = $signed({19'd0, angle_max});
    end
    if (q_val < lo_bound) begin
      clamped = lo_bound;
    end else if (hi_bound < q_val) begin
      clamped = hi_bound;
    end else begin
      clamped = q_val;
    end
  end

  // ---------------- switch and output load ----------------
  logic [15:0] sw_width;
  logic        sw_on;
  logic        out_load;

  assign sw_width = online_flag ? pulse_width[rcpn_pkg::CH_SWITCH]
                                : cal_low[rcpn_pkg::CH_SWITCH];
  assign sw_on    = sw_width > cal_center[rcpn_pkg::CH_SWITCH];
  assign out_load = (state == S_PUSH) && (!out_valid || !out_stall);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ch_idx      <= rcpn_pkg::CH_THROTTLE;
      step_cnt    <= '0;
      online_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch_idx <= channel;
            state  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (op_r == rcpn_pkg::OP_TIMEOUT) begin
            online_flag <= 1'b0;
          end else if (cap_ok && (ch_idx <= rcpn_pkg::CH_THROTTLE)) begin
            online_flag <= 1'b1;
          end
          ch_idx <= rcpn_pkg::CH_THROTTLE;
          state  <= S_MUL;
        end
        S_MUL: begin
          step_cnt <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == rcpn_pkg::DIV_STEP_BITS'(rcpn_pkg::DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // advance throttle, yaw, roll, pitch
          case (ch_idx)
            rcpn_pkg::CH_THROTTLE: begin
              ch_idx <= rcpn_pkg::CH_YAW;
              state  <= S_MUL;
            end
            rcpn_pkg::CH_YAW: begin
              ch_idx <= rcpn_pkg::CH_ROLL;
              state  <= S_MUL;
            end
            rcpn_pkg::CH_ROLL: begin
              ch_idx <= rcpn_pkg::CH_PITCH;
              state  <= S_MUL;
            end
            default: begin
              state <= S_PUSH;
            end
          endcase
        end
        S_PUSH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      op_r   <= opcode;
      rise_r <= rise_time;
      fall_r <= fall_time;
    end
    if (state == S_MUL) begin
      dvd      <= product;
      rem      <= 16'd0;
      dsr      <= den_mag;
      q_neg    <= diff_neg ^ den[16];
      den_zero <= (den == 17'sd0);
      num_zero <= (diff_mag == 16'd0) || (scale == 15'd0);
    end else if (state == S_DIV) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
    if (state == S_FIN) begin
      case (ch_idx)
        rcpn_pkg::CH_THROTTLE: thr_res   <= clamped[14:0];
        rcpn_pkg::CH_YAW:      yaw_res   <= clamped[15:0];
        rcpn_pkg::CH_ROLL:     roll_res  <= clamped[15:0];
        default:               pitch_res <= clamped[15:0];
      endcase
    end
    if (out_load) begin
      throttle    <= thr_res;
      rudder      <= $signed(yaw_res);
      roll        <= $signed(roll_res);
      pitch       <= $signed(pitch_res);
      switch_on   <= sw_on;
      link_online <= online_flag;
    end
  end

  // ---------------- assertions ----------------
  `RCPN_ASSERT_NEXT(a_timeout_drops_link, (state == S_UPDATE) && (op_r == rcpn_pkg::OP_TIMEOUT), !online_flag)
  `RCPN_ASSERT_NEXT(a_push_loads_word, (state == S_PUSH) && !out_valid, out_valid && (link_online == $past(online_flag)))
  `RCPN_ASSERT_IMPL(a_fin_follows_div, (state == S_FIN), ($past(state) == S_DIV))

endmodule
